### hw/rtl/mlp_forward_inference_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checker file of the inference block.
// ----------------------------------------------------------------------------
`ifndef MLP_FORWARD_INFERENCE_MACROS_SVH
`define MLP_FORWARD_INFERENCE_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define MLPFI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is held.
`define MLPFI_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/mlpfi_pkg.sv
// ----------------------------------------------------------------------------
// mlpfi_pkg
// Shared constants, command and register codes and the exp table of the
// network inference block.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpfi_pkg;

    // Network geometry.
    localparam int MAX_LAYERS  = 4;
    localparam int MAX_NEURONS = 64;
    localparam int DATA_W      = 16;
    localparam int N_MAT       = MAX_LAYERS - 1;
    localparam int W_DEPTH     = N_MAT * MAX_NEURONS * MAX_NEURONS;
    localparam int B_DEPTH     = N_MAT * MAX_NEURONS;

    // Divider widths for the softmax normalization.
    localparam int DIVIDEND_W = 34;
    localparam int DIVISOR_W  = 23;

    // Input word kinds.
    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LAYER_COUNT = 3'd0;
    localparam logic [2:0] CFG_INPUT_WIDTH = 3'd1;
    localparam logic [2:0] CFG_HIDDEN_ONE  = 3'd2;
    localparam logic [2:0] CFG_HIDDEN_TWO  = 3'd3;
    localparam logic [2:0] CFG_OUTPUT_W    = 3'd4;
    localparam logic [2:0] CFG_LEAK_SLOPE  = 3'd5;

    // Layer width: zero acts as one, anything above the store saturates.
    function automatic logic [6:0] clamp_width(input logic [6:0] w);
        logic [6:0] r;
        if (w == 7'd0)
            r = 7'd1;
        else if (w > 7'(MAX_NEURONS))
            r = 7'(MAX_NEURONS);
        else
            r = w;
        return r;
    endfunction

    // 2^(-k/16) in unsigned Q1.16, k = 0..16.
    function automatic logic [16:0] pow2_frac(input logic [4:0] k);
        logic [16:0] r;
        case (k)
            5'd0:    r = 17'd65536;
            5'd1:    r = 17'd62757;
            5'd2:    r = 17'd60097;
            5'd3:    r = 17'd57549;
            5'd4:    r = 17'd55109;
            5'd5:    r = 17'd52773;
            5'd6:    r = 17'd50535;
            5'd7:    r = 17'd48393;
            5'd8:    r = 17'd46341;
            5'd9:    r = 17'd44376;
            5'd10:   r = 17'd42495;
            5'd11:   r = 17'd40693;
            5'd12:   r = 17'd38968;
            5'd13:   r = 17'd37316;
            5'd14:   r = 17'd35734;
            5'd15:   r = 17'd34219;
            5'd16:   r = 17'd32768;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mlpfi_divider.sv
// ----------------------------------------------------------------------------
// mlpfi_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpfi_divider
    import mlpfi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [5:0]            cnt_reg;
    logic [DIVISOR_W:0]    rem_reg;
    logic [DIVIDEND_W-1:0] q_reg;
    logic [DIVISOR_W:0]    trial;

    // Shift the next dividend bit into the partial remainder.
    assign trial = {rem_reg[DIVISOR_W-1:0], q_reg[DIVIDEND_W-1]};

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_reg <= trial - {1'b0, divisor};
                q_reg   <= {q_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

### hw/rtl/mlp_forward_inference.sv
// ----------------------------------------------------------------------------
// mlp_forward_inference
// Fully connected network inference with leaky ReLU hidden layers and a
// softmax output layer, on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage. Words enter on the s_axis channel; tuser gives the kind (weight
// load, bias load, sample element). Loads give no result. A sample element
// with tlast set starts the forward pass, during which s_axis_tready is
// low. The pass sends one word per output class on m_axis, in class order,
// with tlast on the last class.
// Each neuron of a layer runs its fan-in through the shared MAC in turn;
// softmax then computes exp for each class, then runs the divider and
// the output handshake for each class. Most of the time of a pass is spent
// in the MAC loop.
// Reset clears the sequencer and loads the register defaults; the weight,
// bias and activation stores are not cleared and must be written before use.
// When the receiver stalls, the current result is held in the output
// register and the sequencer waits; no word is lost.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_forward_inference
    import mlpfi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input words.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] matrix_index, [7:2] row, [13:8] column, [29:14] value, zero above
    input  wire logic [31:0] s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    // Result words.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [5:0] class_index, [21:6] probability, [27:22] best_class, zero above
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    // Configuration writes.
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROW0  = 4'd1;
    localparam logic [3:0] S_MAC   = 4'd2;
    localparam logic [3:0] S_DRAIN = 4'd3;
    localparam logic [3:0] S_ROW1  = 4'd4;
    localparam logic [3:0] S_ROW2  = 4'd5;
    localparam logic [3:0] S_ROW3  = 4'd6;
    localparam logic [3:0] S_EXP0  = 4'd7;
    localparam logic [3:0] S_EXP1  = 4'd8;
    localparam logic [3:0] S_EXP2  = 4'd9;
    localparam logic [3:0] S_EXP3  = 4'd10;
    localparam logic [3:0] S_EXP4  = 4'd11;
    localparam logic [3:0] S_DIV0  = 4'd12;
    localparam logic [3:0] S_DIV1  = 4'd13;
    localparam logic [3:0] S_DIV2  = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    // Configuration registers.
    logic [2:0]  lc_reg;
    logic [6:0]  in_w_reg;
    logic [6:0]  h1_reg;
    logic [6:0]  h2_reg;
    logic [6:0]  out_w_reg;
    logic [15:0] slope_reg;

    // Sequencer.
    logic [3:0] state_reg, state_next;
    logic [1:0] layer_reg, layer_next;
    logic [6:0] row_reg, row_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [6:0] cls_reg, cls_next;
    logic       v1_reg, v2_reg;
    logic       ov_reg, ov_next;
    logic       div_start;

    // Datapath.
    logic signed [15:0] w_rd_reg, b_rd_reg, samp_rd_reg, ping_rd_reg, pong_rd_reg;
    logic        [16:0] ex_rd_reg;
    logic signed [31:0] prod_reg;
    logic signed [39:0] acc_reg;
    logic signed [15:0] x_reg;
    logic signed [32:0] lp_reg;
    logic signed [15:0] mx_reg;
    logic        [5:0]  best_reg;
    logic        [33:0] up_reg;
    logic        [21:0] u_reg;
    logic        [16:0] e_reg;
    logic        [22:0] tot_reg;
    logic        [5:0]  o_class_reg;
    logic        [15:0] o_prob_reg;
    logic        [5:0]  o_best_reg;
    logic               o_last_reg;

    // Stores.
    logic signed [15:0] wmem    [0:W_DEPTH-1];
    logic signed [15:0] bmem    [0:B_DEPTH-1];
    logic signed [15:0] sampmem [0:MAX_NEURONS-1];
    logic signed [15:0] pingmem [0:MAX_NEURONS-1];
    logic signed [15:0] pongmem [0:MAX_NEURONS-1];
    logic        [16:0] exmem   [0:MAX_NEURONS-1];

    logic               in_acc;
    logic [1:0]         in_cmd;
    logic [1:0]         in_mat;
    logic [5:0]         in_row;
    logic [5:0]         in_col;
    logic signed [15:0] in_val;
    logic               four;
    logic [6:0]         w0, w1, w2, w3, nin, nout, n_cls;
    logic               final_layer;
    logic [13:0]        w_raddr;
    logic [7:0]         b_raddr;
    logic [5:0]         act_raddr;
    logic signed [15:0] src_rd, logit_rd;
    logic signed [39:0] sum;
    logic signed [31:0] sum_sh;
    logic signed [15:0] sat_val;
    logic signed [15:0] lp_val;
    logic signed [15:0] y_val;
    logic        [16:0] t_diff;
    logic        [16:0] tab_a, tab_b, tab_d;
    logic        [19:0] d_prod;
    logic        [16:0] e_val;
    logic        [16:0] ex_val;
    logic [DIVIDEND_W-1:0] div_num;
    logic [DIVIDEND_W-1:0] div_q;
    logic               div_done;

    // Input word fields.
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_cmd = s_axis_tuser;
    assign in_mat = s_axis_tdata[1:0];
    assign in_row = s_axis_tdata[7:2];
    assign in_col = s_axis_tdata[13:8];
    assign in_val = $signed(s_axis_tdata[29:14]);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg    <= 3'd3;
            in_w_reg  <= 7'd64;
            h1_reg    <= 7'd64;
            h2_reg    <= 7'd64;
            out_w_reg <= 7'd10;
            slope_reg <= 16'd655;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LAYER_COUNT: lc_reg    <= cfg_data[2:0];
                CFG_INPUT_WIDTH: in_w_reg  <= cfg_data[6:0];
                CFG_HIDDEN_ONE:  h1_reg    <= cfg_data[6:0];
                CFG_HIDDEN_TWO:  h2_reg    <= cfg_data[6:0];
                CFG_OUTPUT_W:    out_w_reg <= cfg_data[6:0];
                CFG_LEAK_SLOPE:  slope_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Layer geometry for the current layer.
    assign four  = (lc_reg >= 3'd4);
    assign w0    = clamp_width(in_w_reg);
    assign w1    = clamp_width(h1_reg);
    assign w2    = clamp_width(h2_reg);
    assign w3    = clamp_width(out_w_reg);
    assign n_cls = four ? w3 : w2;
    assign final_layer = four ? (layer_reg == 2'd2) : (layer_reg == 2'd1);

    always_comb
    begin
        case (layer_reg)
            2'd0:    begin nin = w0; nout = w1; src_rd = samp_rd_reg; end
            2'd1:    begin nin = w1; nout = w2; src_rd = ping_rd_reg; end
            default: begin nin = w2; nout = w3; src_rd = pong_rd_reg; end
        endcase
    end

    assign logit_rd  = four ? ping_rd_reg : pong_rd_reg;
    assign w_raddr   = {layer_reg, row_reg[5:0], cnt_reg[5:0]};
    assign b_raddr   = {layer_reg, row_reg[5:0]};
    assign act_raddr = (state_reg == S_EXP0) ? cls_reg[5:0] : cnt_reg[5:0];

    // Weight store.
    always_ff @(posedge clk)
    begin
        if (in_acc && in_cmd == CMD_WEIGHT && in_mat < 2'(N_MAT))
            wmem[{in_mat, in_row, in_col}] <= in_val;
        w_rd_reg <= wmem[w_raddr];
    end

    // Bias store.
    always_ff @(posedge clk)
    begin
        if (in_acc && in_cmd == CMD_BIAS && in_mat < 2'(N_MAT))
            bmem[{in_mat, in_row}] <= in_val;
        b_rd_reg <= bmem[b_raddr];
    end

    // Sample vector.
    always_ff @(posedge clk)
    begin
        if (in_acc && in_cmd == CMD_SAMPLE)
            sampmem[in_col] <= in_val;
        samp_rd_reg <= sampmem[act_raddr];
    end

    // Activation buffers; layers alternate between them.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROW3 && layer_reg != 2'd1)
            pingmem[row_reg[5:0]] <= y_val;
        ping_rd_reg <= pingmem[act_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROW3 && layer_reg == 2'd1)
            pongmem[row_reg[5:0]] <= y_val;
        pong_rd_reg <= pongmem[act_raddr];
    end

    // Exp values of the output layer.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXP4)
            exmem[cls_reg[5:0]] <= ex_val;
        ex_rd_reg <= exmem[cls_reg[5:0]];
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        layer_next = layer_reg;
        row_next   = row_reg;
        cnt_next   = cnt_reg;
        cls_next   = cls_reg;
        ov_next    = ov_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_cmd == CMD_SAMPLE && s_axis_tlast)
                begin
                    layer_next = 2'd0;
                    row_next   = 7'd0;
                    state_next = S_ROW0;
                end
            end
            S_ROW0:
            begin
                cnt_next   = 7'd0;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == nin - 7'd1)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = S_ROW1;
            end
            S_ROW1: state_next = S_ROW2;
            S_ROW2: state_next = S_ROW3;
            S_ROW3:
            begin
                if (row_reg == nout - 7'd1)
                begin
                    row_next = 7'd0;
                    if (final_layer)
                    begin
                        cls_next   = 7'd0;
                        state_next = S_EXP0;
                    end
                    else
                    begin
                        layer_next = layer_reg + 2'd1;
                        state_next = S_ROW0;
                    end
                end
                else
                begin
                    row_next   = row_reg + 7'd1;
                    state_next = S_ROW0;
                end
            end
            S_EXP0: state_next = S_EXP1;
            S_EXP1: state_next = S_EXP2;
            S_EXP2: state_next = S_EXP3;
            S_EXP3: state_next = S_EXP4;
            S_EXP4:
            begin
                if (cls_reg == n_cls - 7'd1)
                begin
                    cls_next   = 7'd0;
                    state_next = S_DIV0;
                end
                else
                begin
                    cls_next   = cls_reg + 7'd1;
                    state_next = S_EXP0;
                end
            end
            S_DIV0: state_next = S_DIV1;
            S_DIV1:
            begin
                div_start  = 1'b1;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    ov_next    = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    ov_next = 1'b0;
                    if (cls_reg == n_cls - 7'd1)
                        state_next = S_IDLE;
                    else
                    begin
                        cls_next   = cls_reg + 7'd1;
                        state_next = S_DIV0;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            layer_reg <= 2'd0;
            row_reg   <= 7'd0;
            cnt_reg   <= 7'd0;
            cls_reg   <= 7'd0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            row_reg   <= row_next;
            cnt_reg   <= cnt_next;
            cls_reg   <= cls_next;
            v1_reg    <= (state_reg == S_MAC);
            v2_reg    <= v1_reg;
            ov_reg    <= ov_next;
        end
    end

    // Neuron output: bias, round half up, saturate, then leaky ReLU on hidden layers.
    assign sum    = acc_reg + {{16{b_rd_reg[15]}}, b_rd_reg, 8'd0} + 40'sd128;
    assign sum_sh = sum[39:8];
    always_comb
    begin
        if (sum_sh > 32'sd32767)
            sat_val = 16'sd32767;
        else if (sum_sh < -32'sd32768)
            sat_val = -16'sd32768;
        else
            sat_val = sum_sh[15:0];
    end
    assign lp_val = lp_reg[31:16];
    assign y_val  = (!final_layer && lp_val > x_reg) ? lp_val : x_reg;

    // Exp of (logit - max): scale by log2(e), then table and interpolation.
    assign t_diff = 17'({mx_reg[15], mx_reg} - {logit_rd[15], logit_rd});
    assign tab_a  = pow2_frac({1'b0, u_reg[11:8]});
    assign tab_b  = pow2_frac({1'b0, u_reg[11:8]} + 5'd1);
    assign tab_d  = tab_a - tab_b;
    assign d_prod = tab_d[11:0] * u_reg[7:0];
    assign e_val  = tab_a - {5'd0, d_prod[19:8]};
    assign ex_val = (u_reg[21:12] > 10'd16) ? 17'd0 : (e_reg >> u_reg[16:12]);

    // Rounded probability numerator.
    assign div_num = {1'b0, ex_rd_reg, 16'd0} + {12'd0, tot_reg[22:1]};

    // Arithmetic registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROW0)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + {{8{prod_reg[31]}}, prod_reg};
        if (v1_reg)
            prod_reg <= w_rd_reg * src_rd;
        if (state_reg == S_ROW1)
            x_reg <= sat_val;
        if (state_reg == S_ROW2)
            lp_reg <= x_reg * $signed({1'b0, slope_reg});
        if (state_reg == S_ROW3 && final_layer && (row_reg == 7'd0 || y_val > mx_reg))
        begin
            mx_reg   <= y_val;
            best_reg <= row_reg[5:0];
        end
        if (state_reg == S_EXP1)
            up_reg <= {18'd0, t_diff[15:0]} * 34'd94548;
        if (state_reg == S_EXP2)
            u_reg <= 22'((up_reg + 34'd2048) >> 12);
        if (state_reg == S_EXP3)
            e_reg <= e_val;
        if (state_reg == S_IDLE)
            tot_reg <= '0;
        else if (state_reg == S_EXP4)
            tot_reg <= tot_reg + {6'd0, ex_val};
        if (state_reg == S_DIV2 && div_done)
        begin
            o_class_reg <= cls_reg[5:0];
            o_prob_reg  <= (div_q[33:16] != 18'd0) ? 16'hFFFF : div_q[15:0];
            o_best_reg  <= best_reg;
            o_last_reg  <= (cls_reg == n_cls - 7'd1);
        end
    end

    // Shared divider for the softmax normalization.
    mlpfi_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (tot_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Ports.
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {4'd0, o_best_reg, o_prob_reg, o_class_reg};
    assign m_axis_tlast  = o_last_reg;

endmodule

`default_nettype wire

### hw/rtl/mlpfi_checker.sv
// ----------------------------------------------------------------------------
// mlpfi_checker
// Port-level checks of the inference block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mlp_forward_inference_macros.svh"

module mlpfi_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // The block never takes input while a result is pending.
    `MLPFI_ASSERT_RST(a_no_overlap, !(s_axis_tready && m_axis_tvalid), "input taken during output")

    // After a result that is not the last one, the block stays busy.
    `MLPFI_ASSERT(a_busy_after_mid, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready, "ready too early")

    // A stalled result holds.
    `MLPFI_ASSERT(a_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

    // Reset drops the result channel.
    `MLPFI_ASSERT_RST(a_reset_quiet, !rst_n |-> !m_axis_tvalid, "result valid in reset")

endmodule

bind mlp_forward_inference mlpfi_checker u_mlpfi_checker (.*);

`default_nettype wire
